/* sv/v3m_pkg.sv */
// Shared types, constants and helpers for the 3D fixed-point vector unit.
package v3m_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DVD_W      = 32 + FRAC_BITS;   // |a| << FRAC_BITS
    localparam int QUO_W      = DVD_W;            // one quotient bit per divide cell
    localparam int SQRT_STEPS = 32;               // one root bit per sqrt cell
    localparam int LATENCY    = 5 + SQRT_STEPS + QUO_W;

    typedef enum logic [2:0] {
        OP_DOT   = 3'd0,
        OP_LEN   = 3'd1,
        OP_NORM  = 3'd2,
        OP_ADD   = 3'd3,
        OP_SUB   = 3'd4,
        OP_SCALE = 3'd5,
        OP_DIV   = 3'd6,
        OP_EQ    = 3'd7
    } v3m_op_t;

    // transaction payload carried through the front end and the sqrt chain
    typedef struct packed {
        v3m_op_t          op;
        logic [2:0][31:0] a;
        logic [31:0]      s;
        logic [2:0][31:0] r;
        logic [31:0]      sc;
        logic             eq;
    } v3m_item_t;

    typedef struct packed {
        logic [63:0] rad;
        logic [33:0] rem;
        logic [31:0] root;
    } v3m_sq_t;

    // payload carried through the divide chain
    typedef struct packed {
        v3m_op_t          op;
        logic [2:0][31:0] r;
        logic [31:0]      sc;
        logic             eq;
        logic             st;
    } v3m_res_t;

    typedef struct packed {
        logic [31:0]      rem;
        logic [DVD_W-1:0] dvd;
        logic [QUO_W-1:0] quo;
        logic             neg;
    } v3m_lane_t;

    typedef struct packed {
        logic [31:0]          dvsr;
        v3m_lane_t [2:0]      lane;
    } v3m_div_t;

    function automatic logic [31:0] sat32(input logic signed [65:0] v);
        logic [31:0] res;
        if (v > 66'sd2147483647)
            res = 32'h7FFF_FFFF;
        else if (v < -66'sd2147483648)
            res = 32'h8000_0000;
        else
            res = v[31:0];
        return res;
    endfunction

endpackage

/* sv/vector3_math_unit.sv */
// Top level of the 3D fixed-point vector unit: front end, sqrt chain, divide chain, output.
// Path from start to done: front end, sqrt chain, divider setup register, divide chain, output register.
// Throughput: one transaction per cycle; busy is never raised.
// The 32-cell sqrt chain and the (32 + FRAC_BITS)-cell divide chain set the latency.
// Reset (rst_n low, asynchronous) empties the pipeline; done stays low until new work exits.
// Results appear for one cycle with done; the receiver cannot stall them.
module vector3_math_unit
    import v3m_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         req_type,
    input  logic signed [31:0] ax,
    input  logic signed [31:0] ay,
    input  logic signed [31:0] az,
    input  logic signed [31:0] bx,
    input  logic signed [31:0] by,
    input  logic signed [31:0] bz,
    input  logic signed [31:0] scalar,
    output logic               done,
    output logic signed [31:0] rx,
    output logic signed [31:0] ry,
    output logic signed [31:0] rz,
    output logic signed [31:0] scalar_result,
    output logic               equal_flag,
    output logic               status
);

    v3m_item_t   in_item;
    logic        f_valid;
    v3m_item_t   f_item;
    logic [63:0] f_rad;

    logic        sq_valid [SQRT_STEPS+1];
    v3m_item_t   sq_item  [SQRT_STEPS+1];
    v3m_sq_t     sq_st    [SQRT_STEPS+1];

    logic        dv_valid [QUO_W+1];
    v3m_res_t    dv_res   [QUO_W+1];
    v3m_div_t    dv_st    [QUO_W+1];

    logic        setup_valid_reg;
    v3m_res_t    setup_res_reg, setup_res_next;
    v3m_div_t    setup_div_reg, setup_div_next;

    logic        done_reg;
    logic [2:0][31:0] r_reg, r_next;
    logic [31:0] sc_reg;
    logic        eq_reg, st_reg;

    assign busy = 1'b0;

    always_comb
    begin
        in_item      = '0;
        in_item.op   = v3m_op_t'(req_type);
        in_item.a[0] = ax;
        in_item.a[1] = ay;
        in_item.a[2] = az;
        in_item.r[0] = bx;   // b rides in the result slots until the simple ops resolve
        in_item.r[1] = by;
        in_item.r[2] = bz;
        in_item.s    = scalar;
    end

    v3m_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .in_item   (in_item),
        .out_valid (f_valid),
        .out_item  (f_item),
        .out_rad   (f_rad)
    );

    assign sq_valid[0]   = f_valid;
    assign sq_item[0]    = f_item;
    assign sq_st[0].rad  = f_rad;
    assign sq_st[0].rem  = '0;
    assign sq_st[0].root = '0;

    for (genvar g = 0; g < SQRT_STEPS; g++)
    begin : g_sqrt
        v3m_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_valid[g]),
            .in_item   (sq_item[g]),
            .in_sq     (sq_st[g]),
            .out_valid (sq_valid[g+1]),
            .out_item  (sq_item[g+1]),
            .out_sq    (sq_st[g+1])
        );
    end

    // divider setup: pick divisor, flag zero divisor, form operand magnitudes, set the length result
    always_comb
    begin
        v3m_item_t   it;
        logic [31:0] root;
        logic [31:0] s_mag;
        logic [31:0] a_mag;
        it   = sq_item[SQRT_STEPS];
        root = sq_st[SQRT_STEPS].root;
        s_mag = it.s[31] ? (~it.s + 32'd1) : it.s;
        setup_res_next.op = it.op;
        setup_res_next.r  = it.r;
        setup_res_next.sc = it.sc;
        setup_res_next.eq = it.eq;
        setup_res_next.st = 1'b0;
        setup_div_next.dvsr = s_mag;
        case (it.op)
            OP_LEN:
                setup_res_next.sc = sat32(66'(root));
            OP_NORM:
            begin
                setup_div_next.dvsr = root;
                setup_res_next.st   = (root == '0);
            end
            OP_DIV:
                setup_res_next.st = (it.s == '0);
            default:
                setup_res_next.st = 1'b0;
        endcase
        for (int i = 0; i < 3; i++)
        begin
            a_mag = it.a[i][31] ? (~it.a[i] + 32'd1) : it.a[i];
            setup_div_next.lane[i].rem = '0;
            setup_div_next.lane[i].dvd = {a_mag, {FRAC_BITS{1'b0}}};
            setup_div_next.lane[i].quo = '0;
            setup_div_next.lane[i].neg = it.a[i][31] ^ ((it.op == OP_DIV) & it.s[31]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            setup_valid_reg <= 1'b0;
        else
            setup_valid_reg <= sq_valid[SQRT_STEPS];
    end

    always_ff @(posedge clk)
    begin
        setup_res_reg <= setup_res_next;
        setup_div_reg <= setup_div_next;
    end

    assign dv_valid[0] = setup_valid_reg;
    assign dv_res[0]   = setup_res_reg;
    assign dv_st[0]    = setup_div_reg;

    for (genvar g = 0; g < QUO_W; g++)
    begin : g_div
        v3m_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_valid[g]),
            .in_res    (dv_res[g]),
            .in_div    (dv_st[g]),
            .out_valid (dv_valid[g+1]),
            .out_res   (dv_res[g+1]),
            .out_div   (dv_st[g+1])
        );
    end

    // apply signs and saturate quotients, or zero them when status flags a zero divisor
    always_comb
    begin
        v3m_res_t           rs;
        logic signed [65:0] qv;
        rs     = dv_res[QUO_W];
        r_next = rs.r;
        qv     = '0;
        if (rs.op == OP_NORM || rs.op == OP_DIV)
        begin
            for (int i = 0; i < 3; i++)
            begin
                qv = $signed(66'(dv_st[QUO_W].lane[i].quo));
                if (rs.st)
                    r_next[i] = '0;
                else
                    r_next[i] = sat32(dv_st[QUO_W].lane[i].neg ? -qv : qv);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_valid[QUO_W];
    end

    always_ff @(posedge clk)
    begin
        r_reg  <= r_next;
        sc_reg <= dv_res[QUO_W].sc;
        eq_reg <= dv_res[QUO_W].eq;
        st_reg <= dv_res[QUO_W].st;
    end

    assign done          = done_reg;
    assign rx            = r_reg[0];
    assign ry            = r_reg[1];
    assign rz            = r_reg[2];
    assign scalar_result = sc_reg;
    assign equal_flag    = eq_reg;
    assign status        = st_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("transaction did not complete at the expected latency");

    a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
        done && status |-> rx == 0 && ry == 0 && rz == 0 && equal_flag == 1'b0)
        else $error("zero-divisor result carries a nonzero vector or flag");

    a_eq_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done && equal_flag |-> scalar_result == 0 && rx == 0 && !status)
        else $error("equality result carries other fields");

    a_setup_st: assert property (@(posedge clk) disable iff (!rst_n)
        setup_valid_reg && setup_res_reg.st |->
            setup_res_reg.op == OP_NORM || setup_res_reg.op == OP_DIV)
        else $error("status raised for an operation without a divide");

endmodule

/* sv/v3m_front.sv */
// Front end: input register, shared multipliers, sums and the simple operations.
module v3m_front
    import v3m_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  v3m_item_t   in_item,
    output logic        out_valid,
    output v3m_item_t   out_item,
    output logic [63:0] out_rad
);

    logic                    v1_reg, v2_reg, v3_reg;
    v3m_item_t               it1_reg, it2_reg, it3_reg, it3_next;
    logic signed [63:0]      prod_reg [3];
    logic [63:0]             rad_reg, rad_next;
    logic signed [31:0]      mul_b [3];
    logic signed [65:0]      dot_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // operand select so three multipliers serve dot, squares and scale
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            case (it1_reg.op)
                OP_DOT:   mul_b[i] = $signed(it1_reg.r[i]);
                OP_SCALE: mul_b[i] = $signed(it1_reg.s);
                default:  mul_b[i] = $signed(it1_reg.a[i]);
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        it1_reg <= in_item;
        it2_reg <= it1_reg;
        for (int i = 0; i < 3; i++)
            prod_reg[i] <= $signed(it1_reg.a[i]) * mul_b[i];
        it3_reg <= it3_next;
        rad_reg <= rad_next;
    end

    assign dot_sum = 66'(prod_reg[0]) + 66'(prod_reg[1]) + 66'(prod_reg[2]);

    always_comb
    begin
        it3_next    = it2_reg;
        it3_next.r  = '0;
        it3_next.sc = '0;
        it3_next.eq = 1'b0;
        rad_next    = prod_reg[0] + prod_reg[1] + prod_reg[2];
        case (it2_reg.op)
            OP_DOT:
                it3_next.sc = sat32(dot_sum >>> FRAC_BITS);
            OP_ADD:
                for (int i = 0; i < 3; i++)
                    it3_next.r[i] = sat32(66'($signed(it2_reg.a[i])) +
                                          66'($signed(it2_reg.r[i])));
            OP_SUB:
                for (int i = 0; i < 3; i++)
                    it3_next.r[i] = sat32(66'($signed(it2_reg.a[i])) -
                                          66'($signed(it2_reg.r[i])));
            OP_SCALE:
                for (int i = 0; i < 3; i++)
                    it3_next.r[i] = sat32(66'(prod_reg[i] >>> FRAC_BITS));
            OP_EQ:
                it3_next.eq = (it2_reg.a == it2_reg.r);
            default:
                it3_next.eq = 1'b0;
        endcase
    end

    assign out_valid = v3_reg;
    assign out_item  = it3_reg;
    assign out_rad   = rad_reg;

endmodule

/* sv/v3m_sqrt_cell.sv */
// One cell of the square-root chain: resolves one root bit per stage.
module v3m_sqrt_cell
    import v3m_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  v3m_item_t in_item,
    input  v3m_sq_t   in_sq,
    output logic      out_valid,
    output v3m_item_t out_item,
    output v3m_sq_t   out_sq
);

    logic      valid_reg;
    v3m_item_t item_reg;
    v3m_sq_t   sq_reg, sq_next;
    logic [35:0] acc, trial, diff;
    logic        ge;

    always_comb
    begin
        acc   = {in_sq.rem, in_sq.rad[63:62]};
        trial = {2'b00, in_sq.root, 2'b01};
        diff  = acc - trial;
        ge    = (acc >= trial);
        sq_next.rad  = {in_sq.rad[61:0], 2'b00};
        sq_next.rem  = ge ? diff[33:0] : acc[33:0];
        sq_next.root = {in_sq.root[30:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        item_reg <= in_item;
        sq_reg   <= sq_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign out_sq    = sq_reg;

endmodule

/* sv/v3m_div_cell.sv */
// One cell of the divide chain: one restoring quotient bit for all three lanes.
module v3m_div_cell
    import v3m_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  v3m_res_t in_res,
    input  v3m_div_t in_div,
    output logic     out_valid,
    output v3m_res_t out_res,
    output v3m_div_t out_div
);

    logic     valid_reg;
    v3m_res_t res_reg;
    v3m_div_t div_reg, div_next;
    logic [32:0] part [3];
    logic [32:0] diff [3];
    logic        ge   [3];

    always_comb
    begin
        div_next.dvsr = in_div.dvsr;
        for (int i = 0; i < 3; i++)
        begin
            part[i] = {in_div.lane[i].rem, in_div.lane[i].dvd[DVD_W-1]};
            diff[i] = part[i] - {1'b0, in_div.dvsr};
            ge[i]   = (part[i] >= {1'b0, in_div.dvsr});
            div_next.lane[i].rem = ge[i] ? diff[i][31:0] : part[i][31:0];
            div_next.lane[i].dvd = {in_div.lane[i].dvd[DVD_W-2:0], 1'b0};
            div_next.lane[i].quo = {in_div.lane[i].quo[QUO_W-2:0], ge[i]};
            div_next.lane[i].neg = in_div.lane[i].neg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= in_res;
        div_reg <= div_next;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;
    assign out_div   = div_reg;

endmodule

/* verif/tb.sv */
// Self-checking testbench for the 3D fixed-point vector unit.
module tb;
    import v3m_pkg::*;

    typedef struct {
        logic signed [31:0] rx, ry, rz, sc;
        logic               eq, st;
    } vec_result_t;

    // Predicts one result per transaction and checks results in order.
    class vec_scoreboard;
        vec_result_t pending[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        static function logic signed [31:0] clamp32(longint signed v);
            if (v > 64'sd2147483647)
                return 32'h7FFF_FFFF;
            if (v < -64'sd2147483648)
                return 32'h8000_0000;
            return v[31:0];
        endfunction

        // floor shift: arithmetic right shift of a 128-bit signed value
        static function logic signed [127:0] fshift(logic signed [127:0] v);
            return v >>> FRAC_BITS;
        endfunction

        static function logic [63:0] int_sqrt(logic [63:0] n);
            logic [63:0] root, bitv;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > n)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (n >= root + bitv)
                begin
                    n = n - (root + bitv);
                    root = (root >> 1) + bitv;
                end
                else
                    root = root >> 1;
                bitv = bitv >> 2;
            end
            return root;
        endfunction

        function void note_input(v3m_op_t op, logic signed [31:0] a[3],
                                 logic signed [31:0] b[3], logic signed [31:0] s);
            vec_result_t       e;
            logic signed [127:0] acc;
            longint signed     r[3];
            longint signed     len;
            logic [63:0]       sq;
            r = '{0, 0, 0};
            e.sc = 0; e.eq = 0; e.st = 0;
            case (op)
                OP_DOT:
                begin
                    acc = 0;
                    for (int i = 0; i < 3; i++)
                        acc += 128'(a[i]) * 128'(b[i]);
                    acc = fshift(acc);
                    e.sc = (acc > 128'sd2147483647) ? 32'h7FFF_FFFF :
                           (acc < -128'sd2147483648) ? 32'h8000_0000 : acc[31:0];
                end
                OP_LEN, OP_NORM:
                begin
                    sq = 0;
                    for (int i = 0; i < 3; i++)
                        sq += 64'(longint'(a[i]) * longint'(a[i]));
                    len = longint'(int_sqrt(sq));
                    if (op == OP_LEN)
                        e.sc = clamp32(len);
                    else if (len == 0)
                        e.st = 1;
                    else
                        for (int i = 0; i < 3; i++)
                            r[i] = (longint'(a[i]) <<< FRAC_BITS) / len;
                end
                OP_ADD:
                    for (int i = 0; i < 3; i++) r[i] = longint'(a[i]) + b[i];
                OP_SUB:
                    for (int i = 0; i < 3; i++) r[i] = longint'(a[i]) - b[i];
                OP_SCALE:
                    for (int i = 0; i < 3; i++)
                        r[i] = (longint'(a[i]) * longint'(s)) >>> FRAC_BITS;
                OP_DIV:
                    if (s == 0)
                        e.st = 1;
                    else
                        for (int i = 0; i < 3; i++)
                            r[i] = (longint'(a[i]) <<< FRAC_BITS) / longint'(s);
                default:
                    e.eq = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
            endcase
            e.rx = clamp32(r[0]);
            e.ry = clamp32(r[1]);
            e.rz = clamp32(r[2]);
            pending.push_back(e);
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %s: got %0h expected %0h", what, got, want);
            errors++;
        endtask

        task check_result(vec_result_t g);
            vec_result_t e;
            if (pending.size() == 0)
            begin
                report("result with no transaction outstanding", 1, 0);
                return;
            end
            e = pending.pop_front();
            if (g.rx !== e.rx) report("rx", g.rx, e.rx);
            if (g.ry !== e.ry) report("ry", g.ry, e.ry);
            if (g.rz !== e.rz) report("rz", g.rz, e.rz);
            if (g.sc !== e.sc) report("scalar_result", g.sc, e.sc);
            if (g.eq !== e.eq) report("equal_flag", g.eq, e.eq);
            if (g.st !== e.st) report("status", g.st, e.st);
        endtask
    endclass

    logic clk = 0, rst_n = 0, start = 0;
    logic [2:0] req_type = 0;
    logic signed [31:0] ax = 0, ay = 0, az = 0, bx = 0, by = 0, bz = 0, scalar = 0;
    logic busy, done, equal_flag, status;
    logic signed [31:0] rx, ry, rz, scalar_result;
    vec_scoreboard sb = new();
    int cycles = 0;

    localparam int CYCLE_LIMIT = 200000;

    vector3_math_unit uut (.*);

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        vec_result_t g;
        logic signed [31:0] a[3], b[3];
        cycles++;
        if (start && !busy && rst_n)
        begin
            a = '{ax, ay, az};
            b = '{bx, by, bz};
            sb.note_input(v3m_op_t'(req_type), a, b, scalar);
        end
        if (done)
        begin
            g.rx = rx; g.ry = ry; g.rz = rz; g.sc = scalar_result;
            g.eq = equal_flag; g.st = status;
            sb.check_result(g);
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 0;
            3: return $urandom_range(0, 8) << FRAC_BITS;
            4: return -($urandom_range(0, 8) << FRAC_BITS);
            5: return $signed($urandom_range(0, 2000)) - 1000;
            default: return $urandom;
        endcase
    endfunction

    // present one transaction at the falling edge and hold until accepted
    task send(logic [2:0] op, logic [31:0] a0, a1, a2, b0, b1, b2, s);
        @(negedge clk);
        start = 1; req_type = op;
        ax = a0; ay = a1; az = a2; bx = b0; by = b1; bz = b2; scalar = s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task idle();
        @(negedge clk);
        start = 0;
    endtask

    task send_random(logic [2:0] op);
        logic [31:0] a0, a1, a2, b0, b1, b2, s;
        a0 = rand_comp(); a1 = rand_comp(); a2 = rand_comp();
        s = rand_comp();
        if ($urandom_range(0, 3) == 0)
        begin
            b0 = a0; b1 = a1; b2 = a2;
            if ($urandom_range(0, 1)) b1 = b1 ^ (32'd1 << $urandom_range(0, 31));
        end
        else
        begin
            b0 = rand_comp(); b1 = rand_comp(); b2 = rand_comp();
        end
        if (op == OP_NORM && $urandom_range(0, 7) == 0) {a0, a1, a2} = 0;
        if (op == OP_DIV && $urandom_range(0, 7) == 0) s = 0;
        send(op, a0, a1, a2, b0, b1, b2, s);
    endtask

    initial
    begin
        int n;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        // directed: extremes and special cases
        for (int op = 0; op < 8; op++)
        begin
            send(3'(op), 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
            send(3'(op), 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001);
        end
        send(OP_NORM, 0, 0, 0, 1, 2, 3, 5);
        send(OP_DIV, 32'h10000, 32'hFFFF_0000, 5, 0, 0, 0, 0);
        send(OP_EQ, 5, 6, 7, 5, 6, 7, 0);
        send(OP_LEN, 32'h30000, 32'h40000, 0, 0, 0, 0, 0);
        send(OP_DOT, -1, -1, -1, 1, 1, 1, 0);
        send(OP_SCALE, -1, 32'h7FFF_FFFF, 3, 0, 0, 0, 32'hFFFF_FFFF);
        idle();
        // random bursts with gaps
        n = 0;
        while (n < 1150)
        begin
            int burst;
            burst = $urandom_range(1, 40);
            for (int i = 0; i < burst; i++)
            begin
                send_random(3'($urandom_range(0, 7)));
                n++;
            end
            idle();
            if ($urandom_range(0, 2) != 0)
                repeat ($urandom_range(1, 100)) @(posedge clk);
        end
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

/* vector3_math_unit.f */
sv/v3m_pkg.sv
sv/v3m_front.sv
sv/v3m_sqrt_cell.sv
sv/v3m_div_cell.sv
sv/vector3_math_unit.sv
verif/tb.sv
